[rtl/core/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, reset values and transaction payload types.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int PAGE_W         = 16;
  localparam int FRAME_INDEX_W  = 3;
  localparam int COUNT_W        = 32;
  localparam int CFG_W          = 4;
  localparam int FRAMES_DEFAULT = 8;

  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX           = '1;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } req_item_t;

  typedef struct packed {
    logic                     hit;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_W-1:0]        evicted_page;
    logic [COUNT_W-1:0]       fault_count;
    logic [COUNT_W-1:0]       reference_count;
  } rsp_item_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/core/lrupr_ifs.sv]
// ----------------------------------------------------------------------------
// LRU page replacement channels
// Valid/ready channels for references, results and the frame count register.
// ----------------------------------------------------------------------------
interface lrupr_req_if;
  logic                  valid;
  logic                  ready;
  lrupr_pkg::req_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrupr_rsp_if;
  logic                  valid;
  logic                  ready;
  lrupr_pkg::rsp_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrupr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lrupr_pkg::CFG_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/lrupr_cell.sv]
// ----------------------------------------------------------------------------
// LRU page replacement frame cell
// Holds one frame, folds it into the passing search token and applies updates.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int  INDEX  = 0,
  parameter int  IDX_W  = 3,
  parameter int  CNT_W  = 4,
  parameter type token_t = logic,
  parameter type cmd_t   = logic
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lrupr_pkg::PAGE_W-1:0] query_page,
  input  logic [CNT_W-1:0]            active_count,
  input  cmd_t                        cmd,
  input  logic                        tok_in_valid,
  input  token_t                      tok_in,
  output logic                        tok_out_valid,
  output token_t                      tok_out
);
  import lrupr_pkg::*;

  logic [PAGE_W-1:0] page;
  logic              valid;
  logic [IDX_W-1:0]  rank;
  logic              active;
  token_t            tok_next;

  assign active = CNT_W'(INDEX) < active_count;

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit_found && active && valid && page == query_page) begin
      tok_next.hit_found = 1'b1;
      tok_next.hit_idx   = IDX_W'(INDEX);
      tok_next.hit_rank  = rank;
    end
    if (!tok_in.empty_found && active && !valid) begin
      tok_next.empty_found = 1'b1;
      tok_next.empty_idx   = IDX_W'(INDEX);
      tok_next.empty_rank  = rank;
    end
    if (active && (!tok_in.max_found || rank > tok_in.max_rank)) begin
      tok_next.max_found = 1'b1;
      tok_next.max_idx   = IDX_W'(INDEX);
      tok_next.max_rank  = rank;
      tok_next.max_page  = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in_valid) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= IDX_W'(INDEX);
    end else if (cmd.en) begin
      if (cmd.clear) begin
        valid <= 1'b0;
        rank  <= IDX_W'(INDEX);
      end else if (cmd.idx == IDX_W'(INDEX)) begin
        rank <= '0;
        if (cmd.wr) begin
          valid <= 1'b1;
        end
      end else if (rank < cmd.old_rank) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.wr && cmd.idx == IDX_W'(INDEX)) begin
      page <= cmd.page;
    end
  end

endmodule

[rtl/core/lru_page_replacement_core.sv]
// ----------------------------------------------------------------------------
// LRU page replacement core
// One reference is handled at a time: a new one is accepted only in the idle
// state, once the result of the last one has been committed. The search token
// steps through one frame cell per cycle. Reset clears the frames, the
// counts and the recency order, and sets frames_in_use to 8.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  lrupr_cfg_if.sink   cfg,
  lrupr_req_if.sink   req,
  lrupr_rsp_if.source rsp
);
  import lrupr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  typedef struct packed {
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  hit_rank;
    logic              empty_found;
    logic [IDX_W-1:0]  empty_idx;
    logic [IDX_W-1:0]  empty_rank;
    logic              max_found;
    logic [IDX_W-1:0]  max_idx;
    logic [IDX_W-1:0]  max_rank;
    logic [PAGE_W-1:0] max_page;
  } token_t;

  typedef struct packed {
    logic              en;
    logic              wr;
    logic              clear;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  old_rank;
    logic [PAGE_W-1:0] page;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CFG_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]   active_count;
  logic [PAGE_W-1:0]  query_page;
  logic               query_last;
  logic [COUNT_W-1:0] faults;
  logic [COUNT_W-1:0] references;
  logic [COUNT_W-1:0] faults_next;
  logic [COUNT_W-1:0] references_next;
  token_t             result_tok;
  cmd_t               cmd;
  rsp_item_t          rsp_next;
  logic               commit;
  logic [IDX_W-1:0]   frame_sel;
  logic               start;

  token_t             tok [FRAMES+1];
  logic [FRAMES:0]    tok_valid;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign commit    = (state == S_COMMIT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RESET;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.data;
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      active_count = CNT_W'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      active_count = CNT_W'(FRAMES);
    end else begin
      active_count = CNT_W'(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= req.valid && req.ready;
    end
  end

  assign tok[0]       = '0;
  assign tok_valid[0] = start;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .INDEX   (i),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .token_t (token_t),
      .cmd_t   (cmd_t)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .query_page    (query_page),
      .active_count  (active_count),
      .cmd           (cmd),
      .tok_in_valid  (tok_valid[i]),
      .tok_in        (tok[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out       (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      query_page <= req.data.page_number;
      query_last <= req.data.last_reference;
    end
    if (tok_valid[FRAMES]) begin
      result_tok <= tok[FRAMES];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_valid[FRAMES]) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.en    = commit;
    cmd.clear = query_last;
    cmd.page  = query_page;
    rsp_next  = '0;
    if (result_tok.hit_found) begin
      cmd.wr       = 1'b0;
      cmd.idx      = result_tok.hit_idx;
      cmd.old_rank = result_tok.hit_rank;
      rsp_next.hit = 1'b1;
    end else if (result_tok.empty_found) begin
      cmd.wr       = 1'b1;
      cmd.idx      = result_tok.empty_idx;
      cmd.old_rank = result_tok.empty_rank;
    end else begin
      cmd.wr                 = 1'b1;
      cmd.idx                = result_tok.max_idx;
      cmd.old_rank           = result_tok.max_rank;
      rsp_next.evicted_valid = 1'b1;
      rsp_next.evicted_page  = result_tok.max_page;
    end
    frame_sel       = cmd.idx;
    faults_next     = result_tok.hit_found ? faults : sat_inc(faults);
    references_next = sat_inc(references);
    rsp_next.frame_index     = FRAME_INDEX_W'(frame_sel);
    rsp_next.fault_count     = faults_next;
    rsp_next.reference_count = references_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      faults     <= '0;
      references <= '0;
    end else if (commit) begin
      if (query_last) begin
        faults     <= '0;
        references <= '0;
      end else begin
        faults     <= faults_next;
        references <= references_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.data <= rsp_next;
    end
  end

endmodule
